// File: sv/rpn_pkg.sv
// Package: shared constants, codes and types of the postfix expression evaluator.
`default_nettype none
package rpn_pkg;

  localparam int STACK_DEPTH = 32;
  localparam int DATA_W      = 32;
  localparam int OPND_W      = 31;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W      = $clog2(STACK_DEPTH);

  typedef enum logic [1:0] {
    REQ_NUMBER,
    REQ_OPERATOR,
    REQ_ILLEGAL,
    REQ_END
  } req_type_e;

  typedef enum logic [1:0] {
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV
  } op_code_e;

  typedef enum logic [2:0] {
    ST_OK,
    ST_TOO_MANY_OPS,
    ST_ILLEGAL,
    ST_TOO_FEW_OPS,
    ST_OVERFLOW,
    ST_DIV_ZERO,
    ST_EMPTY
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_DIV
  } state_e;

  typedef struct packed {
    logic              start;
    logic [DATA_W-1:0] dividend;
    logic [DATA_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] quotient;
  } div_rsp_t;

endpackage
`default_nettype wire

// File: sv/rpn_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module rpn_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

// File: sv/rpn_div.sv
// Iterative signed divider, truncating toward zero, one quotient bit per cycle.
`default_nettype none
module rpn_div (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire rpn_pkg::div_req_t req_i,
  output rpn_pkg::div_rsp_t      rsp_o
);
  import rpn_pkg::*;

  localparam int ITER_W = $clog2(DATA_W);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [ITER_W-1:0] iter_q, iter_d;
  logic              neg_q, neg_d;
  logic [DATA_W-1:0] rem_q, rem_d;
  logic [DATA_W-1:0] quo_q, quo_d;
  logic [DATA_W-1:0] den_q, den_d;
  logic [DATA_W:0]   trial;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    iter_d = iter_q;
    neg_d  = neg_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    trial  = {rem_q, quo_q[DATA_W-1]} - {1'b0, den_q};
    if (req_i.start) begin
      busy_d = 1'b1;
      iter_d = '0;
      neg_d  = req_i.dividend[DATA_W-1] ^ req_i.divisor[DATA_W-1];
      rem_d  = '0;
      quo_d  = req_i.dividend[DATA_W-1] ? (DATA_W'(0) - req_i.dividend) : req_i.dividend;
      den_d  = req_i.divisor[DATA_W-1] ? (DATA_W'(0) - req_i.divisor) : req_i.divisor;
    end else if (busy_q) begin
      if (trial[DATA_W]) begin
        rem_d = {rem_q[DATA_W-2:0], quo_q[DATA_W-1]};
        quo_d = {quo_q[DATA_W-2:0], 1'b0};
      end else begin
        rem_d = trial[DATA_W-1:0];
        quo_d = {quo_q[DATA_W-2:0], 1'b1};
      end
      iter_d = iter_q + ITER_W'(1);
      if (iter_q == ITER_W'(DATA_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      iter_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      iter_q <= iter_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = neg_q ? (DATA_W'(0) - quo_q) : quo_q;

endmodule
`default_nettype wire

// File: sv/postfix_expression_evaluator_top.sv
// Top level: postfix expression evaluator with a RAM operand stack and a cached top value.
// Number, illegal and end requests are handled when accepted; add, subtract and multiply also pass
// through S_EXEC, which waits for the read of the second operand from the stack RAM.
// Divide does the stack read, then the 32 steps of the iterative divider (S_DIV) plus hand-back.
// An end request's result appears in the output register the cycle after it is accepted.
// Reset empties the stack and clears the pending error; the stack RAM itself is not cleared.
`default_nettype none
module postfix_expression_evaluator_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [39:0] s_axis_tdata,  // operand[30:0], op_code[32:31], zero[39:33]
  input  wire logic [1:0]  s_axis_tuser,  // req_type[1:0]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [31:0] m_axis_tdata,  // result[31:0]
  output logic      [2:0]  m_axis_tuser   // status[2:0]
);
  import rpn_pkg::*;

  state_e            state_q, state_d;
  logic [CNT_W-1:0]  count_q, count_d;
  status_e           err_q, err_d;
  logic [DATA_W-1:0] tos_q, tos_d;
  op_code_e          op_q, op_d;
  logic              out_valid_q, out_valid_d;
  status_e           out_status_q, out_status_d;
  logic [DATA_W-1:0] out_result_q, out_result_d;

  logic              accept;
  req_type_e         req_type;
  op_code_e          req_op;
  logic [OPND_W-1:0] req_operand;
  logic              op_start;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic [DATA_W-1:0] ram_rdata;

  div_req_t          div_req;
  div_rsp_t          div_rsp;

  assign req_type    = req_type_e'(s_axis_tuser);
  assign req_operand = s_axis_tdata[OPND_W-1:0];
  assign req_op      = op_code_e'(s_axis_tdata[OPND_W+1:OPND_W]);

  assign s_axis_tready = (state_q == S_IDLE) && (!out_valid_q || m_axis_tready);
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign op_start = accept && (req_type == REQ_OPERATOR) && (err_q == ST_OK)
                    && (count_q >= CNT_W'(2))
                    && !((req_op == OP_DIV) && (tos_q == '0));

  rpn_ram #(
    .WIDTH (DATA_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (tos_q),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  rpn_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (op_start) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d = (op_q == OP_DIV) ? S_DIV : S_IDLE;
      end
      S_DIV: begin
        if (div_rsp.done) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    count_d          = count_q;
    err_d            = err_q;
    tos_d            = tos_q;
    op_d             = op_q;
    out_valid_d      = out_valid_q && !m_axis_tready;
    out_status_d     = out_status_q;
    out_result_d     = out_result_q;
    ram_we           = 1'b0;
    ram_waddr        = ADDR_W'(count_q - CNT_W'(1));
    ram_re           = 1'b0;
    ram_raddr        = ADDR_W'(count_q - CNT_W'(2));
    div_req.start    = 1'b0;
    div_req.dividend = ram_rdata;
    div_req.divisor  = tos_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (req_type == REQ_END) begin
            out_valid_d  = 1'b1;
            out_result_d = '0;
            if (err_q != ST_OK) begin
              out_status_d = err_q;
            end else if (count_q == '0) begin
              out_status_d = ST_EMPTY;
            end else if (count_q != CNT_W'(1)) begin
              out_status_d = ST_TOO_FEW_OPS;
            end else begin
              out_status_d = ST_OK;
              out_result_d = tos_q;
            end
            count_d = '0;
            err_d   = ST_OK;
          end else if (err_q == ST_OK) begin
            unique case (req_type)
              REQ_NUMBER: begin
                if (count_q == CNT_W'(STACK_DEPTH)) begin
                  err_d = ST_OVERFLOW;
                end else begin
                  ram_we  = (count_q != '0);
                  tos_d   = {1'b0, req_operand};
                  count_d = count_q + CNT_W'(1);
                end
              end
              REQ_OPERATOR: begin
                if (count_q < CNT_W'(2)) begin
                  err_d = ST_TOO_MANY_OPS;
                end else if ((req_op == OP_DIV) && (tos_q == '0)) begin
                  err_d = ST_DIV_ZERO;
                end else begin
                  ram_re = 1'b1;
                  op_d   = req_op;
                end
              end
              default: err_d = ST_ILLEGAL;
            endcase
          end
        end
      end
      S_EXEC: begin
        unique case (op_q)
          OP_ADD:  tos_d = ram_rdata + tos_q;
          OP_SUB:  tos_d = ram_rdata - tos_q;
          OP_MUL:  tos_d = ram_rdata * tos_q;
          default: div_req.start = 1'b1;
        endcase
        if (op_q != OP_DIV) begin
          count_d = count_q - CNT_W'(1);
        end
      end
      S_DIV: begin
        if (div_rsp.done) begin
          tos_d   = div_rsp.quotient;
          count_d = count_q - CNT_W'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      err_q       <= ST_OK;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      err_q       <= err_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tos_q        <= tos_d;
    op_q         <= op_d;
    out_status_q <= out_status_d;
    out_result_q <= out_result_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_result_q;
  assign m_axis_tuser  = out_status_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(STACK_DEPTH))
    else $error("stack count above depth");

  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (req_type == REQ_END)) |=> ((count_q == '0) && (err_q == ST_OK) && out_valid_q))
    else $error("end request did not clear the expression");

  a_error_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_status_q != ST_OK)) |-> (out_result_q == '0))
    else $error("nonzero result with error status");

  a_busy_operands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> ((count_q >= CNT_W'(2)) && (err_q == ST_OK)))
    else $error("operator in progress without two operands");

endmodule
`default_nettype wire

// File: test/postfix_expression_evaluator_top_tb.sv
// Testbench: directed and random postfix token streams, results checked against a stack evaluator.
module postfix_expression_evaluator_top_tb;
  import rpn_pkg::*;

  localparam int unsigned TOKEN_GOAL  = 1650;
  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int unsigned REPORT_CAP  = 30;

  typedef struct {
    status_e     status;
    logic [31:0] value;
  } outcome_t;

  class expr_scoreboard;
    logic [31:0] stack_mem [STACK_DEPTH];
    int unsigned depth;
    status_e     pending;
    outcome_t    outcome_q [$];
    int unsigned mismatches;
    int unsigned status_seen [7];

    function new();
      depth      = 0;
      pending    = ST_OK;
      mismatches = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    function void note_request(req_type_e kind, logic [30:0] opnd, op_code_e op);
      outcome_t    done_expr;
      logic [31:0] a, b, r, ma, mb, q;
      if (kind == REQ_END) begin
        done_expr.value = '0;
        if (pending != ST_OK) begin
          done_expr.status = pending;
        end else if (depth == 0) begin
          done_expr.status = ST_EMPTY;
        end else if (depth > 1) begin
          done_expr.status = ST_TOO_FEW_OPS;
        end else begin
          done_expr.status = ST_OK;
          done_expr.value  = stack_mem[0];
        end
        outcome_q.push_back(done_expr);
        depth   = 0;
        pending = ST_OK;
        return;
      end
      if (pending != ST_OK) return;
      case (kind)
        REQ_NUMBER: begin
          if (depth >= STACK_DEPTH) begin
            pending = ST_OVERFLOW;
          end else begin
            stack_mem[depth] = {1'b0, opnd};
            depth++;
          end
        end
        REQ_OPERATOR: begin
          if (depth < 2) begin
            pending = ST_TOO_MANY_OPS;
            return;
          end
          a = stack_mem[depth-1];
          b = stack_mem[depth-2];
          case (op)
            OP_ADD: r = b + a;
            OP_SUB: r = b - a;
            OP_MUL: r = b * a;
            default: begin
              if (a == '0) begin
                pending = ST_DIV_ZERO;
                return;
              end
              ma = a[31] ? -a : a;
              mb = b[31] ? -b : b;
              q  = mb / ma;
              r  = (a[31] ^ b[31]) ? -q : q;
            end
          endcase
          depth--;
          stack_mem[depth-1] = r;
        end
        default: pending = ST_ILLEGAL;
      endcase
    endfunction

    task report(string msg);
      mismatches++;
      if (mismatches <= REPORT_CAP) $display("[%0t] MISMATCH: %s", $time, msg);
    endtask

    task check_result(logic [2:0] status, logic [31:0] value);
      outcome_t want;
      if (outcome_q.size() == 0) begin
        report($sformatf("unexpected result status %0d value %h", status, value));
        return;
      end
      want = outcome_q.pop_front();
      if (status !== want.status)
        report($sformatf("status %0d, want %s", status, want.status.name()));
      if (value !== want.value)
        report($sformatf("value %h, want %h (%s)", value, want.value, want.status.name()));
      status_seen[int'(want.status)]++;
    endtask
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;

  bit             idle_on = 1'b1;
  int unsigned    tokens_sent = 0;
  int unsigned    exprs_sent  = 0;
  int unsigned    cycle_count = 0;
  expr_scoreboard sb;

  postfix_expression_evaluator_top u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               sb.outcome_q.size());
      $display("** postfix_expression_evaluator_top: FAILED **");
      $finish;
    end
  end

  always begin
    @(posedge clk_i);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      m_axis_tready <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    m_axis_tready <= 1'b1;
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tuser, m_axis_tdata);
  end

  function automatic op_code_e rand_op();
    return op_code_e'($urandom_range(0, 3));
  endfunction

  function automatic logic [30:0] rand_operand();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return 31'h7FFF_FFFF;
      2, 3:    return 31'($urandom_range(1, 3));
      4, 5, 6: return 31'($urandom_range(0, 20));
      7:       return 31'($urandom_range(0, 65535));
      default: return 31'($urandom);
    endcase
  endfunction

  task automatic send_token(req_type_e kind, logic [30:0] opnd, op_code_e op);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {7'd0, op, opnd};
    do @(posedge clk_i); while (s_axis_tready !== 1'b1);
    sb.note_request(kind, opnd, op);
    tokens_sent++;
    if (tokens_sent >= TOKEN_GOAL * 17 / 20) idle_on = 1'b0;
  endtask

  task automatic push_value(logic [30:0] opnd);
    send_token(REQ_NUMBER, opnd, rand_op());
  endtask

  task automatic apply_op(op_code_e op);
    send_token(REQ_OPERATOR, 31'($urandom), op);
  endtask

  task automatic close_expr();
    send_token(REQ_END, 31'($urandom), rand_op());
    exprs_sent++;
  endtask

  task automatic send_noise(int unsigned count);
    repeat (count) send_token(req_type_e'($urandom_range(0, 2)), 31'($urandom), rand_op());
  endtask

  task automatic send_random_expression();
    int unsigned mode, n_vals, pushed, depth, flaw, bad_at, emitted, pct;
    mode = $urandom_range(0, 99);
    if (mode < 4) begin
      close_expr();
      return;
    end
    if (mode < 9) begin
      repeat (STACK_DEPTH + $urandom_range(1, 3)) push_value(rand_operand());
      send_noise($urandom_range(0, 3));
      close_expr();
      return;
    end
    if (mode < 17) begin
      send_noise($urandom_range(1, 10));
      close_expr();
      return;
    end
    flaw   = (mode < 29) ? $urandom_range(1, 3) : 0;
    n_vals = (mode >= 95) ? $urandom_range(20, STACK_DEPTH) : $urandom_range(1, 6);
    if (flaw == 1 && n_vals < 2) n_vals = 2;
    pct     = (mode >= 95) ? 90 : 55;
    bad_at  = $urandom_range(0, 2 * n_vals);
    pushed  = 0;
    depth   = 0;
    emitted = 0;
    while (pushed < n_vals || depth > ((flaw == 1) ? 2 : 1)) begin
      if (flaw == 3 && emitted == bad_at) send_token(REQ_ILLEGAL, 31'($urandom), rand_op());
      if (pushed < n_vals && (depth < 2 || $urandom_range(1, 100) <= pct)) begin
        push_value(rand_operand());
        pushed++;
        depth++;
      end else begin
        apply_op(rand_op());
        depth--;
      end
      emitted++;
    end
    if (flaw == 2) apply_op(rand_op());
    if (flaw == 3 && emitted <= bad_at) send_token(REQ_ILLEGAL, 31'($urandom), rand_op());
    close_expr();
  endtask

  initial begin
    sb = new();
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= REQ_NUMBER;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    close_expr();
    push_value(31'h7FFF_FFFF);
    push_value(31'd1);
    apply_op(OP_ADD);
    push_value(31'd0);
    push_value(31'd1);
    apply_op(OP_SUB);
    apply_op(OP_DIV);
    close_expr();
    push_value(31'd6);
    push_value(31'd0);
    apply_op(OP_DIV);
    push_value(31'd9);
    close_expr();
    push_value(31'd3);
    apply_op(OP_MUL);
    close_expr();
    send_token(REQ_ILLEGAL, 31'h5555_5555, OP_SUB);
    push_value(31'd1);
    close_expr();
    push_value(31'd1);
    push_value(31'd2);
    close_expr();
    push_value(31'h0001_2345);
    push_value(31'h7FFF_FFFF);
    apply_op(OP_MUL);
    close_expr();

    while (tokens_sent < TOKEN_GOAL) send_random_expression();
    s_axis_tvalid <= 1'b0;

    while (sb.outcome_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);

    $display("ran %0d tokens in %0d expressions over %0d cycles", tokens_sent, exprs_sent,
             cycle_count);
    $display("results: ok %0d, op excess %0d, illegal %0d, op shortage %0d, overflow %0d, %s%0d, %s%0d",
             sb.status_seen[0], sb.status_seen[1], sb.status_seen[2], sb.status_seen[3],
             sb.status_seen[4], "div by zero ", sb.status_seen[5], "empty ",
             sb.status_seen[6]);
    if (sb.mismatches == 0) begin
      $display("** postfix_expression_evaluator_top: PASSED **");
    end else begin
      $display("** postfix_expression_evaluator_top: FAILED **");
    end
    $finish;
  end

endmodule
